// File: rtl/svt_pkg.sv
// ----------------------------------------------------------------------------
// svt_pkg
// Shared types and constants for the sorted value table.
// ----------------------------------------------------------------------------
`default_nettype none

package svt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int VAL_W       = 32;
	localparam int OUT_CNT_W   = 5;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_DUP      = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_DECIDE,
		S_SHUP_RD,
		S_SHUP_WR,
		S_SHDN_RD,
		S_SHDN_WR,
		S_ENDS,
		S_MIN_CAP,
		S_MAX_CAP,
		S_FIN
	} state_t;

	typedef struct packed {
		status_t                  status;
		logic                     found;
		logic [OUT_CNT_W-1:0]     entry_count;
		logic signed [VAL_W-1:0]  smallest;
		logic signed [VAL_W-1:0]  largest;
		logic                     empty_res;
	} res_t;

endpackage

`default_nettype wire

// File: rtl/svt_engine.sv
// ----------------------------------------------------------------------------
// svt_engine
// Table memory and the sequencer that scans, shifts and reports on it.
// ----------------------------------------------------------------------------
`default_nettype none

module svt_engine (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	input  svt_pkg::cmd_t                      cmd,
	input  wire signed [svt_pkg::VAL_W-1:0]    value,
	output logic                               ready,
	input  wire                                res_free,
	output logic                               res_push,
	output svt_pkg::res_t                      res
);

	localparam int IW = svt_pkg::IDX_W;
	localparam int CW = svt_pkg::CNT_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(svt_pkg::TABLE_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	logic signed [svt_pkg::VAL_W-1:0] mem [svt_pkg::TABLE_DEPTH];
	logic signed [svt_pkg::VAL_W-1:0] rd_data_q;
	logic                             mem_we;
	logic [IW-1:0]                    mem_waddr;
	logic [IW-1:0]                    mem_raddr;
	logic signed [svt_pkg::VAL_W-1:0] mem_wdata;

	svt_pkg::state_t                  state_q, state_d;
	svt_pkg::cmd_t                    cmd_q;
	svt_pkg::status_t                 status_q;
	logic signed [svt_pkg::VAL_W-1:0] val_q, min_q, max_q;
	logic [CW-1:0]                    count_q, j_q, pos_q;
	logic                             hit_q, found_q;

	logic [CW-1:0] j_inc, j_dec, cnt_dec;
	logic          ge, full;

	assign j_inc   = j_q + ONE_C;
	assign j_dec   = j_q - ONE_C;
	assign cnt_dec = count_q - ONE_C;
	assign ge      = (rd_data_q >= val_q);
	assign full    = (count_q == DEPTH_C);

	// table with one write port and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ready     = 1'b0;
		res_push  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = j_q[IW-1:0];
		mem_wdata = rd_data_q;
		mem_raddr = j_q[IW-1:0];
		case (state_q)
			svt_pkg::S_IDLE: begin
				ready = 1'b1;
				if (start) begin
					if (cmd == svt_pkg::CMD_CLEAR) begin
						state_d = svt_pkg::S_FIN;
					end else if (count_q == '0) begin
						state_d = svt_pkg::S_DECIDE;
					end else begin
						state_d = svt_pkg::S_SCAN_RD;
					end
				end
			end
			svt_pkg::S_SCAN_RD: begin
				state_d = svt_pkg::S_SCAN_CMP;
			end
			svt_pkg::S_SCAN_CMP: begin
				if (ge || j_inc == count_q) begin
					state_d = svt_pkg::S_DECIDE;
				end else begin
					state_d = svt_pkg::S_SCAN_RD;
				end
			end
			svt_pkg::S_DECIDE: begin
				state_d = svt_pkg::S_ENDS;
				if (cmd_q == svt_pkg::CMD_INSERT && !hit_q && !full) begin
					state_d = svt_pkg::S_SHUP_RD;
				end else if (cmd_q == svt_pkg::CMD_DELETE && hit_q) begin
					state_d = svt_pkg::S_SHDN_RD;
				end
			end
			svt_pkg::S_SHUP_RD: begin
				mem_raddr = j_dec[IW-1:0];
				if (j_q == pos_q) begin
					// slot is open: drop the new value in
					mem_we    = 1'b1;
					mem_waddr = pos_q[IW-1:0];
					mem_wdata = val_q;
					state_d   = svt_pkg::S_ENDS;
				end else begin
					state_d = svt_pkg::S_SHUP_WR;
				end
			end
			svt_pkg::S_SHUP_WR: begin
				mem_we  = 1'b1;
				state_d = svt_pkg::S_SHUP_RD;
			end
			svt_pkg::S_SHDN_RD: begin
				mem_raddr = j_inc[IW-1:0];
				if (j_inc >= count_q) begin
					state_d = svt_pkg::S_ENDS;
				end else begin
					state_d = svt_pkg::S_SHDN_WR;
				end
			end
			svt_pkg::S_SHDN_WR: begin
				mem_we  = 1'b1;
				state_d = svt_pkg::S_SHDN_RD;
			end
			svt_pkg::S_ENDS: begin
				mem_raddr = '0;
				if (count_q == '0) begin
					state_d = svt_pkg::S_FIN;
				end else begin
					state_d = svt_pkg::S_MIN_CAP;
				end
			end
			svt_pkg::S_MIN_CAP: begin
				mem_raddr = cnt_dec[IW-1:0];
				state_d   = svt_pkg::S_MAX_CAP;
			end
			svt_pkg::S_MAX_CAP: begin
				state_d = svt_pkg::S_FIN;
			end
			svt_pkg::S_FIN: begin
				if (res_free) begin
					res_push = 1'b1;
					state_d  = svt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = svt_pkg::S_IDLE;
			end
		endcase
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (state_q)
				svt_pkg::S_IDLE: begin
					if (start && cmd == svt_pkg::CMD_CLEAR) begin
						count_q <= '0;
					end
				end
				svt_pkg::S_SHUP_RD: begin
					if (j_q == pos_q) begin
						count_q <= count_q + ONE_C;
					end
				end
				svt_pkg::S_SHDN_RD: begin
					if (j_inc >= count_q) begin
						count_q <= cnt_dec;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			svt_pkg::S_IDLE: begin
				if (start) begin
					cmd_q    <= cmd;
					val_q    <= value;
					j_q      <= '0;
					pos_q    <= '0;
					hit_q    <= 1'b0;
					status_q <= svt_pkg::ST_OK;
					found_q  <= 1'b0;
				end
			end
			svt_pkg::S_SCAN_CMP: begin
				if (ge) begin
					pos_q <= j_q;
					hit_q <= (rd_data_q == val_q);
				end else begin
					j_q   <= j_inc;
					pos_q <= j_inc;
				end
			end
			svt_pkg::S_DECIDE: begin
				case (cmd_q)
					svt_pkg::CMD_INSERT: begin
						j_q <= count_q;
						if (hit_q) begin
							status_q <= svt_pkg::ST_DUP;
							found_q  <= 1'b1;
						end else if (full) begin
							status_q <= svt_pkg::ST_FULL;
						end
					end
					svt_pkg::CMD_DELETE: begin
						j_q <= pos_q;
						if (count_q == '0) begin
							status_q <= svt_pkg::ST_EMPTY;
						end else if (!hit_q) begin
							status_q <= svt_pkg::ST_NOTFOUND;
						end else begin
							found_q <= 1'b1;
						end
					end
					default: begin
						if (hit_q) begin
							found_q <= 1'b1;
						end else begin
							status_q <= svt_pkg::ST_NOTFOUND;
						end
					end
				endcase
			end
			svt_pkg::S_SHUP_WR: begin
				j_q <= j_dec;
			end
			svt_pkg::S_SHDN_WR: begin
				j_q <= j_inc;
			end
			svt_pkg::S_ENDS: begin
				min_q <= '0;
				max_q <= '0;
			end
			svt_pkg::S_MIN_CAP: begin
				min_q <= rd_data_q;
			end
			svt_pkg::S_MAX_CAP: begin
				max_q <= rd_data_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.status      = status_q;
		res.found       = found_q;
		res.entry_count = svt_pkg::OUT_CNT_W'(count_q);
		res.empty_res   = (count_q == '0);
		res.smallest    = (count_q == '0) ? '0 : min_q;
		res.largest     = (count_q == '0) ? '0 : max_q;
	end

endmodule

`default_nettype wire

// File: rtl/svt_out.sv
// ----------------------------------------------------------------------------
// svt_out
// Result holding register between the sequencer and the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module svt_out (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  svt_pkg::res_t  res_in,
	output logic           free,
	output logic           valid,
	input  wire            take,
	output svt_pkg::res_t  res_out
);

	logic          valid_q;
	svt_pkg::res_t res_q;

	assign free    = !valid_q || take;
	assign valid   = valid_q;
	assign res_out = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res_in;
		end
	end

endmodule

`default_nettype wire

// File: rtl/sorted_value_table_top.sv
// ----------------------------------------------------------------------------
// sorted_value_table_top
// Ascending table of distinct signed values with insert, delete, search and
// clear commands; one status result per command.
//
// Channel   Direction  Width     Contents
// s_axis    in         32 / 2    tdata: value; tuser: command
// m_axis    out        80        tdata: status, found, entry_count, smallest,
//                                largest, empty_res
//
// Steps per command: accept; a linear scan, reading then comparing each slot
// (none on an empty table); decide; a read and a write per entry moved, plus
// a last step when an insert stores or a delete removes; read the ends unless
// the table ends empty; hand over the result. Clear goes from accept to the
// hand-over. One command at a time: s_axis_tready is high only while idle; the
// hand-over waits for a free output register. Reset empties table, not memory.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_value_table_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,   // [31:0] value
	input  wire  [1:0]  s_axis_tuser,   // [1:0] command
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [79:0] m_axis_tdata    // [2:0] status, [3] found, [8:4] entry_count,
	                                    // [40:9] smallest, [72:41] largest,
	                                    // [73] empty_res, [79:74] zero
);

	logic          eng_ready;
	logic          res_free;
	logic          res_push;
	svt_pkg::res_t eng_res;
	svt_pkg::res_t out_res;

	assign s_axis_tready = eng_ready;

	svt_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_axis_tvalid && eng_ready),
		.cmd      (svt_pkg::cmd_t'(s_axis_tuser)),
		.value    (s_axis_tdata),
		.ready    (eng_ready),
		.res_free (res_free),
		.res_push (res_push),
		.res      (eng_res)
	);

	svt_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.res_in  (eng_res),
		.free    (res_free),
		.valid   (m_axis_tvalid),
		.take    (m_axis_tready),
		.res_out (out_res)
	);

	assign m_axis_tdata = {6'd0, out_res.empty_res, out_res.largest, out_res.smallest,
	                       out_res.entry_count, out_res.found, out_res.status};

endmodule

`default_nettype wire
